### sv/bso_pkg.sv
// Shared types and widths for the box/sphere overlap pipeline.
package bso_pkg;

  localparam int CenterW = 24;              // signed Q15.8 center
  localparam int SizeW   = 23;              // unsigned Q15.8 extent or diameter
  localparam int Center2W = CenterW + 2;    // difference of doubled centers
  localparam int DistW   = CenterW + 1;     // magnitude of that difference
  localparam int LimW    = SizeW + 1;       // sum of two sizes
  localparam int RadW    = SizeW + 1;       // sum of two diameters
  localparam int DistSqW = 2 * DistW;
  localparam int RadSqW  = 2 * RadW;
  localparam int SumW    = DistSqW + 2;     // three squares added
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = CenterW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_IS_SPHERE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CENTER_X  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CENTER_Y  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CENTER_Z  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SIZE_X    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Y    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Z    = 3'd6;

  typedef struct packed {
    logic                            is_sphere;
    logic [2:0][CenterW-1:0]         center;
    logic [2:0][SizeW-1:0]           size;
  } vol_t;

  // after stage 1: per-axis center distance and limit
  typedef struct packed {
    logic                            box_box;
    logic [2:0][DistW-1:0]           delta;
    logic [2:0][LimW-1:0]            lim;
    logic [RadW-1:0]                 radius;
  } s1_t;

  // after stage 2: per-axis excess past the limit
  typedef struct packed {
    logic                            box_box;
    logic                            box_hit;
    logic [2:0][DistW-1:0]           excess;
    logic [RadW-1:0]                 radius;
  } s2_t;

  // after stage 3: squares
  typedef struct packed {
    logic                            box_box;
    logic                            box_hit;
    logic [2:0][DistSqW-1:0]         excess_sq;
    logic [RadSqW-1:0]               radius_sq;
  } s3_t;

endpackage

### sv/bso_delta.sv
// Stage 1: center distance per axis, axis limit and radius selection.
module bso_delta (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          valid_in,
  input  bso_pkg::vol_t query,
  input  bso_pkg::vol_t other,
  output logic          valid,
  output bso_pkg::s1_t  data
);

  logic [2:0][bso_pkg::Center2W-1:0] qc2;
  logic [2:0][bso_pkg::Center2W-1:0] oc2;
  logic [2:0][bso_pkg::Center2W-1:0] diff_qo;
  logic [2:0][bso_pkg::Center2W-1:0] diff_oq;
  logic [2:0][bso_pkg::LimW-1:0]     size_sum;
  logic                              q_sph;
  logic                              o_sph;
  bso_pkg::s1_t                      data_next;

  assign q_sph = query.is_sphere;
  assign o_sph = other.is_sphere;

  always_comb begin
    data_next = '0;
    data_next.box_box = !q_sph && !o_sph;
    for (int i = 0; i < 3; i++) begin
      qc2[i] = {query.center[i][bso_pkg::CenterW-1], query.center[i], 1'b0};
      oc2[i] = {other.center[i][bso_pkg::CenterW-1], other.center[i], 1'b0};
      diff_qo[i] = qc2[i] - oc2[i];
      diff_oq[i] = oc2[i] - qc2[i];
      size_sum[i] = {1'b0, query.size[i]} + {1'b0, other.size[i]};
      data_next.delta[i] = diff_qo[i][bso_pkg::Center2W-1] ?
                           diff_oq[i][bso_pkg::DistW-1:0] : diff_qo[i][bso_pkg::DistW-1:0];
      // box-box: strict |d| < sum of sizes; mixed: the box size; sphere pair: none
      unique case ({q_sph, o_sph})
        2'b00:   data_next.lim[i] = size_sum[i];
        2'b10:   data_next.lim[i] = {1'b0, other.size[i]};
        2'b01:   data_next.lim[i] = {1'b0, query.size[i]};
        default: data_next.lim[i] = '0;
      endcase
    end
    unique case ({q_sph, o_sph})
      2'b11:   data_next.radius = size_sum[0];
      2'b10:   data_next.radius = {1'b0, query.size[0]};
      2'b01:   data_next.radius = {1'b0, other.size[0]};
      default: data_next.radius = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_next;
    end
  end

endmodule

### sv/bso_excess.sv
// Stage 2: distance beyond each axis limit, and the box-box axis tests.
module bso_excess (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic         valid_in,
  input  bso_pkg::s1_t data_in,
  output logic         valid,
  output bso_pkg::s2_t data
);

  logic [2:0][bso_pkg::DistW:0] diff;
  logic [2:0]                   inside_lim;
  bso_pkg::s2_t                 data_next;

  always_comb begin
    data_next = '0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {1'b0, data_in.delta[i]} - {2'b00, data_in.lim[i]};
      inside_lim[i] = diff[i][bso_pkg::DistW];
      data_next.excess[i] = inside_lim[i] ? '0 : diff[i][bso_pkg::DistW-1:0];
    end
    data_next.box_box = data_in.box_box;
    data_next.box_hit = &inside_lim;
    data_next.radius  = data_in.radius;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_next;
    end
  end

endmodule

### sv/bso_square.sv
// Stage 3: squares of the per-axis excess and of the radius.
module bso_square (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic         valid_in,
  input  bso_pkg::s2_t data_in,
  output logic         valid,
  output bso_pkg::s3_t data
);

  bso_pkg::s3_t data_next;

  always_comb begin
    data_next = '0;
    for (int i = 0; i < 3; i++) begin
      data_next.excess_sq[i] = bso_pkg::DistSqW'(data_in.excess[i]) *
                               bso_pkg::DistSqW'(data_in.excess[i]);
    end
    data_next.radius_sq = bso_pkg::RadSqW'(data_in.radius) *
                          bso_pkg::RadSqW'(data_in.radius);
    data_next.box_box = data_in.box_box;
    data_next.box_hit = data_in.box_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_next;
    end
  end

endmodule

### sv/bso_compare.sv
// Stage 4: box hit, or squares sum < squared radius; holds the output word.
module bso_compare (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic         valid_in,
  input  bso_pkg::s3_t data_in,
  output logic         valid,
  output logic         hit
);

  logic [bso_pkg::SumW-1:0] total;
  logic                     hit_next;

  always_comb begin
    total = bso_pkg::SumW'(data_in.excess_sq[0]) + bso_pkg::SumW'(data_in.excess_sq[1]) +
            bso_pkg::SumW'(data_in.excess_sq[2]);
    hit_next = data_in.box_box ? data_in.box_hit
                               : (total < bso_pkg::SumW'(data_in.radius_sq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit <= hit_next;
    end
  end

endmodule

### sv/box_sphere_overlap_test_core.sv
// Box/sphere overlap test: configured query volume against a stream of volumes.
//
// Strict overlap test of a configured query volume (box or sphere) against one
// incoming volume per word, exact in doubled Q15.8 units. The pipeline has four
// register stages (distance, excess past limits, 25x25 squares, sum and compare)
// and takes one word every cycle unless in_stall is high; the first stage captures
// the word at the edge that takes it, and the excess, square and compare stages
// follow in order. A stall holds the full stages back to the first bubble;
// stages behind a bubble move up into it. Query registers are written through
// cfg_write/cfg_index/cfg_data and should only change while no word is in flight.
module box_sphere_overlap_test_core (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  // input words
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                other_is_sphere,
  input  logic signed [23:0]  other_center_x,
  input  logic signed [23:0]  other_center_y,
  input  logic signed [23:0]  other_center_z,
  input  logic [22:0]         other_size_x,
  input  logic [22:0]         other_size_y,
  input  logic [22:0]         other_size_z,
  // result words
  output logic                out_valid,
  input  logic                out_stall,
  output logic                overlapping
);

  logic                       query_is_sphere;
  logic [2:0][23:0]           query_center;
  logic [2:0][22:0]           query_size;

  bso_pkg::vol_t              query;
  bso_pkg::vol_t              other;
  bso_pkg::s1_t               s1_data;
  bso_pkg::s2_t               s2_data;
  bso_pkg::s3_t               s3_data;
  logic                       s1_valid;
  logic                       s2_valid;
  logic                       s3_valid;
  logic                       load1;
  logic                       load2;
  logic                       load3;
  logic                       load4;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_is_sphere <= 1'b0;
      query_center    <= '0;
      query_size      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bso_pkg::REG_IS_SPHERE: query_is_sphere <= cfg_data[0];
        bso_pkg::REG_CENTER_X:  query_center[0] <= cfg_data;
        bso_pkg::REG_CENTER_Y:  query_center[1] <= cfg_data;
        bso_pkg::REG_CENTER_Z:  query_center[2] <= cfg_data;
        bso_pkg::REG_SIZE_X:    query_size[0]   <= cfg_data[22:0];
        bso_pkg::REG_SIZE_Y:    query_size[1]   <= cfg_data[22:0];
        bso_pkg::REG_SIZE_Z:    query_size[2]   <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  assign query.is_sphere = query_is_sphere;
  assign query.center    = query_center;
  assign query.size      = query_size;

  assign other.is_sphere = other_is_sphere;
  assign other.center    = {other_center_z, other_center_y, other_center_x};
  assign other.size      = {other_size_z, other_size_y, other_size_x};

  // a stage loads when it is empty or its contents move on
  assign load4    = !out_valid || !out_stall;
  assign load3    = !s3_valid || load4;
  assign load2    = !s2_valid || load3;
  assign load1    = !s1_valid || load2;
  assign in_stall = !load1;

  bso_delta u_delta (
    .clk      (clk),
    .rst      (rst),
    .load     (load1),
    .valid_in (in_valid),
    .query    (query),
    .other    (other),
    .valid    (s1_valid),
    .data     (s1_data)
  );

  bso_excess u_excess (
    .clk      (clk),
    .rst      (rst),
    .load     (load2),
    .valid_in (s1_valid),
    .data_in  (s1_data),
    .valid    (s2_valid),
    .data     (s2_data)
  );

  bso_square u_square (
    .clk      (clk),
    .rst      (rst),
    .load     (load3),
    .valid_in (s2_valid),
    .data_in  (s2_data),
    .valid    (s3_valid),
    .data     (s3_data)
  );

  bso_compare u_compare (
    .clk      (clk),
    .rst      (rst),
    .load     (load4),
    .valid_in (s3_valid),
    .data_in  (s3_data),
    .valid    (out_valid),
    .hit      (overlapping)
  );

endmodule

### test/tb_box_sphere_overlap_test_core.sv
// Testbench for box_sphere_overlap_test_core: random and directed volumes against a predictor.
`timescale 1ns / 1ps

module tb_box_sphere_overlap_test_core;

  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;
  localparam int SMAX = 8388607;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        other_is_sphere = 1'b0;
  logic signed [23:0] other_center_x = '0;
  logic signed [23:0] other_center_y = '0;
  logic signed [23:0] other_center_z = '0;
  logic [22:0] other_size_x = '0;
  logic [22:0] other_size_y = '0;
  logic [22:0] other_size_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        overlapping;

  box_sphere_overlap_test_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .other_is_sphere(other_is_sphere),
    .other_center_x(other_center_x), .other_center_y(other_center_y),
    .other_center_z(other_center_z),
    .other_size_x(other_size_x), .other_size_y(other_size_y), .other_size_z(other_size_z),
    .out_valid(out_valid), .out_stall(out_stall), .overlapping(overlapping)
  );

  always #1 clk = ~clk;

  bso_pkg::vol_t pending_volumes[$];
  bit            expected_overlap[$];
  bso_pkg::vol_t query_vol = '0;
  bso_pkg::vol_t next_word;
  bso_pkg::vol_t seen_word;
  bit   want_hit;
  bit   calm = 1'b0;
  bit   in_taken = 1'b0;
  int   send_gap = 0;
  int   recv_wait = 0;
  int   errors = 0;
  int   sent_count = 0;
  int   results_seen = 0;
  int   hits_seen = 0;
  int   settings_count = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic longint cval(logic [23:0] c);
    return longint'($signed(c));
  endfunction

  function automatic logic [23:0] sat_center(longint v);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v[23:0];
  endfunction

  // exact test in doubled units: bounds are 2*center -/+ size, doubled radius is the diameter
  function automatic bit predict_overlap(bso_pkg::vol_t q, bso_pkg::vol_t o);
    bso_pkg::vol_t sp, bx;
    longint a2, b2, qs, os, lo, hi, p, d, dsum, r;
    dsum = 0;
    if (!q.is_sphere && !o.is_sphere) begin
      for (int i = 0; i < 3; i++) begin
        a2 = 2 * cval(q.center[i]);
        b2 = 2 * cval(o.center[i]);
        qs = longint'(q.size[i]);
        os = longint'(o.size[i]);
        if (!(a2 + qs > b2 - os) || !(a2 - qs < b2 + os)) return 1'b0;
      end
      return 1'b1;
    end
    if (q.is_sphere && o.is_sphere) begin
      for (int i = 0; i < 3; i++) begin
        d = 2 * cval(q.center[i]) - 2 * cval(o.center[i]);
        dsum += d * d;
      end
      r = longint'(q.size[0]) + longint'(o.size[0]);
      return dsum < r * r;
    end
    // mixed pair: clamp the sphere center into the box
    sp = q.is_sphere ? q : o;
    bx = q.is_sphere ? o : q;
    for (int i = 0; i < 3; i++) begin
      p  = 2 * cval(sp.center[i]);
      lo = 2 * cval(bx.center[i]) - longint'(bx.size[i]);
      hi = 2 * cval(bx.center[i]) + longint'(bx.size[i]);
      d  = p;
      if (d < lo) d = lo;
      if (d > hi) d = hi;
      d = d - p;
      dsum += d * d;
    end
    r = longint'(sp.size[0]);
    return dsum < r * r;
  endfunction

  function automatic bso_pkg::vol_t mk(bit sph, int cx, int cy, int cz, int sx, int sy, int sz);
    bso_pkg::vol_t v;
    v.is_sphere = sph;
    v.center[0] = cx[23:0];
    v.center[1] = cy[23:0];
    v.center[2] = cz[23:0];
    v.size[0] = sx[22:0];
    v.size[1] = sy[22:0];
    v.size[2] = sz[22:0];
    return v;
  endfunction

  function automatic logic [22:0] rand_size(int scale);
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return 23'(SMAX);
    case (scale)
      0: return 23'($urandom_range(0, 1023));
      1: return 23'($urandom_range(0, 65535));
      default: return 23'($urandom_range(0, SMAX));
    endcase
  endfunction

  function automatic bso_pkg::vol_t rand_any();
    bso_pkg::vol_t o;
    o.is_sphere = 1'($urandom_range(0, 1));
    for (int i = 0; i < 3; i++) begin
      o.center[i] = sat_center(longint'($urandom_range(0, 16777215)) - 8388608);
      o.size[i] = 23'($urandom_range(0, SMAX));
    end
    return o;
  endfunction

  // center offset spread over about 1.25x the combined reach, so hits and misses mix
  function automatic bso_pkg::vol_t rand_near(bso_pkg::vol_t q, int scale);
    bso_pkg::vol_t o;
    longint qe, oe, span, off;
    o.is_sphere = 1'($urandom_range(0, 1));
    for (int i = 0; i < 3; i++) o.size[i] = rand_size(scale);
    for (int i = 0; i < 3; i++) begin
      qe = longint'(q.is_sphere ? q.size[0] : q.size[i]);
      oe = longint'(o.is_sphere ? o.size[0] : o.size[i]);
      span = (qe + oe) * 5 / 4 + 2;
      off = longint'($urandom_range(0, 32'(2 * span))) - span;
      o.center[i] = sat_center(cval(q.center[i]) + off / 2);
    end
    return o;
  endfunction

  // exact contact on one axis, sometimes nudged by one LSB either way
  function automatic bso_pkg::vol_t rand_touch(bso_pkg::vol_t q, int scale);
    bso_pkg::vol_t o;
    int     ax, k;
    longint qe, oe, step;
    o = rand_near(q, scale);
    ax = $urandom_range(0, 2);
    k = o.is_sphere ? 0 : ax;
    qe = longint'(q.is_sphere ? q.size[0] : q.size[ax]);
    if ((qe + longint'(o.size[k])) % 2 != 0) o.size[k] = o.size[k] ^ 23'd1;
    oe = longint'(o.size[k]);
    o.center = q.center;
    step = (qe + oe) / 2;
    if ($urandom_range(0, 1)) step = -step;
    if ($urandom_range(0, 1)) step = step + longint'($urandom_range(0, 2)) - 1;
    o.center[ax] = sat_center(cval(q.center[ax]) + step);
    return o;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // unused upper data bits carry junk; the block must ignore them
  task automatic write_query(input bso_pkg::vol_t v);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(bso_pkg::REG_IS_SPHERE, {junk[22:0], v.is_sphere});
    write_reg(bso_pkg::REG_CENTER_X, v.center[0]);
    write_reg(bso_pkg::REG_CENTER_Y, v.center[1]);
    write_reg(bso_pkg::REG_CENTER_Z, v.center[2]);
    write_reg(bso_pkg::REG_SIZE_X, {junk[23], v.size[0]});
    write_reg(bso_pkg::REG_SIZE_Y, {junk[24], v.size[1]});
    write_reg(bso_pkg::REG_SIZE_Z, {junk[25], v.size[2]});
    @(negedge clk);
    cfg_write <= 1'b0;
    query_vol = v;
    settings_count++;
  endtask

  task automatic wait_all_done();
    while (pending_volumes.size() != 0 || in_valid || expected_overlap.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // sender: next word goes out once the current one is taken and its gap has run out
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_volumes.size() != 0) begin
        next_word = pending_volumes.pop_front();
        other_is_sphere <= next_word.is_sphere;
        other_center_x  <= next_word.center[0];
        other_center_y  <= next_word.center[1];
        other_center_z  <= next_word.center[2];
        other_size_x    <= next_word.size[0];
        other_size_y    <= next_word.size[1];
        other_size_z    <= next_word.size[2];
        in_valid <= 1'b1;
        send_gap = draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen_word.is_sphere = other_is_sphere;
        seen_word.center[0] = other_center_x;
        seen_word.center[1] = other_center_y;
        seen_word.center[2] = other_center_z;
        seen_word.size[0] = other_size_x;
        seen_word.size[1] = other_size_y;
        seen_word.size[2] = other_size_z;
        expected_overlap.push_back(predict_overlap(query_vol, seen_word));
        in_taken = 1'b1;
        sent_count++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        recv_wait = draw_wait();
        if (expected_overlap.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          want_hit = expected_overlap.pop_front();
          if (overlapping !== want_hit)
            report_mismatch($sformatf("word %0d: overlapping %b, expected %b",
                                      results_seen, overlapping, want_hit));
          if (want_hit) hits_seen++;
        end
      end
    end
  end

  initial begin
    #500000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    bso_pkg::vol_t qv;
    int   scale;
    int   kind;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: the query is a zero-size box at the origin
    pending_volumes.push_back(mk(0, 0, 0, 0, 512, 512, 512));
    pending_volumes.push_back(mk(1, 0, 0, 0, 512, 0, 0));
    wait_all_done();

    write_query(mk(0, 0, 0, 0, 512, 512, 512));
    pending_volumes.push_back(mk(0, 0, 0, 0, 512, 512, 512));
    pending_volumes.push_back(mk(0, 512, 0, 0, 512, 512, 512));   // faces touch
    pending_volumes.push_back(mk(0, 511, 0, 0, 512, 512, 512));
    pending_volumes.push_back(mk(0, 0, -512, 0, 512, 512, 512));  // faces touch
    pending_volumes.push_back(mk(0, 0, 0, 0, 512, 0, 512));       // flat box
    pending_volumes.push_back(mk(1, 0, 0, 0, 256, 0, 0));
    pending_volumes.push_back(mk(1, 0, 0, 0, 0, 0, 0));           // point sphere
    pending_volumes.push_back(mk(1, 512, 0, 0, 512, 0, 0));       // sphere on box face
    pending_volumes.push_back(mk(1, 511, 0, 0, 512, 0, 0));
    pending_volumes.push_back(mk(1, 300, 300, 0, 200, SMAX, SMAX));
    pending_volumes.push_back(mk(0, CMAX, CMAX, CMAX, SMAX, SMAX, SMAX));
    pending_volumes.push_back(mk(0, CMIN, CMIN, CMIN, SMAX, SMAX, SMAX));
    pending_volumes.push_back(mk(1, CMIN, CMAX, CMIN, SMAX, 0, 0));
    wait_all_done();

    write_query(mk(1, 0, 0, 0, 512, SMAX, SMAX));
    pending_volumes.push_back(mk(1, 512, 0, 0, 512, 0, 0));       // spheres touch
    pending_volumes.push_back(mk(1, 511, 0, 0, 512, 0, 0));
    pending_volumes.push_back(mk(0, 512, 0, 0, 512, 512, 512));   // box face on sphere
    pending_volumes.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    pending_volumes.push_back(mk(1, CMIN, CMIN, CMIN, SMAX, SMAX, SMAX));
    pending_volumes.push_back(mk(0, CMAX, CMAX, CMAX, SMAX, SMAX, SMAX));
    wait_all_done();

    write_query(mk(1, CMIN, CMIN, CMIN, SMAX, 0, 0));
    pending_volumes.push_back(mk(1, CMAX, CMAX, CMAX, SMAX, 0, 0));
    pending_volumes.push_back(mk(0, CMAX, CMAX, CMAX, SMAX, SMAX, SMAX));
    wait_all_done();

    write_query(mk(0, CMAX, CMAX, CMAX, SMAX, SMAX, SMAX));
    pending_volumes.push_back(mk(0, CMIN, CMIN, CMIN, SMAX, SMAX, SMAX));
    pending_volumes.push_back(mk(1, CMIN, CMIN, CMIN, SMAX, SMAX, SMAX));
    wait_all_done();

    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph % 4 == 1);
      scale = ph % 3;
      qv.is_sphere = 1'($urandom_range(0, 1));
      for (int i = 0; i < 3; i++) begin
        qv.size[i] = rand_size(scale);
        if ($urandom_range(0, 1))
          qv.center[i] = sat_center(longint'($urandom_range(0, 16777215)) - 8388608);
        else
          qv.center[i] = sat_center(longint'($urandom_range(0, 2047)) - 1024);
      end
      write_query(qv);
      for (int n = 0; n < 108; n++) begin
        // in every third phase, halfway through, hold the sender until the pipeline has drained
        if (n == 54 && ph % 3 == 2) wait_all_done();
        kind = $urandom_range(0, 7);
        if (kind == 0) pending_volumes.push_back(rand_any());
        else if (kind < 3) pending_volumes.push_back(rand_touch(qv, scale));
        else pending_volumes.push_back(rand_near(qv, scale));
      end
      wait_all_done();
    end

    $display("covered %0d words over %0d query settings: %0d overlaps, %0d misses",
             sent_count, settings_count, hits_seen, results_seen - hits_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
